[rtl/core/slts_pkg.sv]
// Package for the sparse lower triangular solve core.
// Holds payload structs, status and state codes, divider handshake types and constants.
// No dependencies.
package slts_pkg;

  // Field widths fixed by the interface
  localparam int unsigned COL_W       = 12;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ROW_COUNT_W = 13;

  // Divider operand widths: |acc| * 2^16 over |coeff|
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 32;

  // Defaults and constants
  localparam int unsigned          MAX_ROWS_DEF    = 4096;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 13'd4096;
  localparam logic signed [DATA_W-1:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [DATA_W-1:0] S32_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_DIAG = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] coeff;
    logic                     is_diagonal;
  } slts_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic signed [DATA_W-1:0] solution;
    status_e                  status;
    logic                     solve_done;
  } slts_out_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic                     sat;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/sparse_lower_triangular_solve_core.sv]
// Sparse lower triangular solve, x = L^-1 * 1, signed Q16.16, CSR order input.
// Top level: sequencer, multiply-accumulate path, solution RAM and divider.
// Depends on slts_pkg, slts_ram and slts_div.
//
// Feed the matrix row by row, one nonzero per transfer, rows 0, 1, 2 ... with
// the diagonal last in each row; every diagonal produces one result transfer
// carrying x[row], and solve_done marks the last row, after which the core
// starts again at row 0. A column at or beyond the current row reads as 1.0.
// One item is processed at a time. An off-diagonal entry goes through the
// solution RAM read, 32x32 multiply, then subtract and saturate. A diagonal
// runs the 48-step bit-serial divider, plus any wait for the output register
// to drain; a zero diagonal skips the divider. The solution RAM needs no
// clearing pass: a column's stored value is only used once its row has been
// written in the current matrix. row_count may only be written while the core
// is idle.
module sparse_lower_triangular_solve_core
  import slts_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ROW_COUNT_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  slts_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output slts_out_t              out_data_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  // Compare width covering the row counter, the column and row_count
  localparam int unsigned CW = ((RW > ROW_COUNT_W) ? RW : ROW_COUNT_W) + 1;
  localparam logic [CW-1:0] MAX_ROWS_C = CW'(MAX_ROWS);

  state_e state_q, state_d;

  logic [ROW_COUNT_W-1:0]   row_count_q;
  logic [RW-1:0]            cur_row_q;
  logic signed [DATA_W-1:0] acc_q;
  logic                     ovf_q;
  logic signed [DATA_W-1:0] coeff_q;
  logic                     use_store_q;
  logic signed [63:0]       prod_q;
  logic signed [DATA_W-1:0] sol_q;
  status_e                  status_q;
  logic                     out_valid_q;
  slts_out_t                out_q;

  logic in_xfer;
  logic slot_free;
  logic do_read;
  logic do_mul;
  logic do_acc;
  logic do_zero;
  logic do_fin;
  logic div_start;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [RW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  logic [CW-1:0] col_w;
  logic [CW-1:0] cur_w;
  logic [CW-1:0] cur_inc;
  logic [CW-1:0] rows_eff;
  logic          last_row;

  logic signed [DATA_W-1:0] xv;
  logic signed [63:0]       prod_d;
  logic signed [47:0]       prod_sh;
  logic signed [48:0]       diff;
  logic                     diff_sat;
  logic signed [DATA_W-1:0] acc_sat;
  logic [DATA_W-1:0]        acc_abs;
  logic [DATA_W-1:0]        coeff_abs;

  // Row bookkeeping
  always_comb begin
    col_w    = CW'(in_data_i.column);
    cur_w    = CW'(cur_row_q);
    cur_inc  = cur_w + 1'b1;
    if (row_count_q == '0) begin
      rows_eff = CW'(1);
    end else if (CW'(row_count_q) > MAX_ROWS_C) begin
      rows_eff = MAX_ROWS_C;
    end else begin
      rows_eff = CW'(row_count_q);
    end
    last_row = (cur_inc >= rows_eff);
  end

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!in_data_i.is_diagonal) begin
            state_d = ST_MUL;
          end else if (in_data_i.coeff == '0) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = ST_IDLE;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    do_read    = 1'b0;
    do_mul     = 1'b0;
    do_acc     = 1'b0;
    do_zero    = 1'b0;
    do_fin     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_xfer) begin
          do_read   = !in_data_i.is_diagonal;
          do_zero   = in_data_i.is_diagonal && (in_data_i.coeff == '0);
          div_start = in_data_i.is_diagonal && (in_data_i.coeff != '0);
        end
      end
      ST_MUL: do_mul = 1'b1;
      ST_ACC: do_acc = 1'b1;
      ST_DIV: ;
      ST_FIN: do_fin = slot_free;
      default: ;
    endcase
  end

  // Divider operands: magnitudes and quotient sign
  always_comb begin
    acc_abs       = acc_q[DATA_W-1] ? DATA_W'(-acc_q) : DATA_W'(acc_q);
    coeff_abs     = in_data_i.coeff[DATA_W-1] ? DATA_W'(-in_data_i.coeff)
                                              : DATA_W'(in_data_i.coeff);
    div_req.start = div_start;
    div_req.neg   = acc_q[DATA_W-1] ^ in_data_i.coeff[DATA_W-1];
    div_req.num   = {acc_abs, 16'h0000};
    div_req.den   = coeff_abs;
  end

  slts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Solution store: read on off-diagonal accept, written when a row closes
  assign ram_addr = do_fin ? cur_row_q : col_w[RW-1:0];

  slts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_fin),
    .addr_i  (ram_addr),
    .wdata_i (sol_q),
    .rdata_o (ram_rdata)
  );

  // Multiply, then floor shift, subtract and saturate
  always_comb begin
    xv       = use_store_q ? $signed(ram_rdata) : ONE_Q16;
    prod_d   = coeff_q * xv;
    prod_sh  = prod_q[63:16];
    diff     = 49'(acc_q) - 49'(prod_sh);
    diff_sat = (diff > 49'(S32_MAX)) || (diff < 49'(S32_MIN));
    if (diff > 49'(S32_MAX)) begin
      acc_sat = S32_MAX;
    end else if (diff < 49'(S32_MIN)) begin
      acc_sat = S32_MIN;
    end else begin
      acc_sat = diff[DATA_W-1:0];
    end
  end

  // Control and row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_count_q <= ROW_COUNT_RESET;
      cur_row_q   <= '0;
      acc_q       <= ONE_Q16;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
      if (do_acc) begin
        acc_q <= acc_sat;
        ovf_q <= ovf_q | diff_sat;
      end
      if (do_fin) begin
        cur_row_q   <= last_row ? '0 : cur_inc[RW-1:0];
        acc_q       <= ONE_Q16;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (do_read) begin
      coeff_q     <= in_data_i.coeff;
      use_store_q <= (col_w < cur_w) && (col_w < MAX_ROWS_C);
    end
    if (do_mul) begin
      prod_q <= prod_d;
    end
    if (do_zero) begin
      sol_q    <= acc_q[DATA_W-1] ? S32_MIN : S32_MAX;
      status_q <= STATUS_ZERO_DIAG;
    end else if ((state_q == ST_DIV) && div_rsp.done) begin
      sol_q    <= div_rsp.quot;
      status_q <= (ovf_q || div_rsp.sat) ? STATUS_OVERFLOW : STATUS_OK;
    end
    if (do_fin) begin
      out_q.row_index  <= cur_w[ROW_W-1:0];
      out_q.solution   <= sol_q;
      out_q.status     <= status_q;
      out_q.solve_done <= last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_diag_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == ST_DIV))
    else $error("nonzero diagonal did not enter division");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_fin && last_row) |=> (cur_row_q == '0) && out_data_o.solve_done)
    else $error("last row did not wrap the row counter");

  a_zero_diag_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STATUS_ZERO_DIAG)) |->
      ((out_data_o.solution == S32_MAX) || (out_data_o.solution == S32_MIN)))
    else $error("zero diagonal result not saturated");

endmodule

[rtl/core/slts_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module slts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/core/slts_div.sv]
// Iterative restoring divider, one quotient bit per cycle, with signed saturation.
// Depends on slts_pkg.
module slts_div
  import slts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(S32_MAX);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h1_0000_0000 >> 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic             sat;

  // One shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      den_q <= req_i.den;
      neg_q <= req_i.neg;
    end
  end

  // Sign and saturate the magnitude quotient
  always_comb begin
    sat = neg_q ? (quo_q > NEG_LIM) : (quo_q > POS_LIM);
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    rsp_o.sat  = sat;
    if (sat) begin
      rsp_o.quot = neg_q ? S32_MIN : S32_MAX;
    end else if (neg_q) begin
      rsp_o.quot = -$signed(quo_q[DATA_W-1:0]);
    end else begin
      rsp_o.quot = $signed(quo_q[DATA_W-1:0]);
    end
  end

endmodule

[sim/slts_solve_checker.sv]
`timescale 1ns / 100ps
// Checker for the sparse lower triangular solve core: tracks the solve in Q16.16
// and compares every result transfer, field by field, with the predicted row solution.
// Depends on slts_pkg only; instantiated beside the core by the testbench top.
module slts_solve_checker
  import slts_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ROW_COUNT_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  slts_in_t               in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  slts_out_t              out_data_i,
  output int unsigned            mismatches_o,
  output int unsigned            pending_o,
  output int unsigned            entries_o,
  output int unsigned            solved_rows_o,
  output int unsigned            zero_diags_o,
  output int unsigned            saturations_o,
  output int unsigned            matrices_o
);

  // Own copy of the solve state
  logic signed [DATA_W-1:0] x_store [MAX_ROWS];
  int unsigned              row_ptr;
  logic signed [DATA_W-1:0] acc;
  logic                     acc_sat;
  logic [ROW_COUNT_W-1:0]   row_limit;
  slts_out_t                pending_solutions [$];

  function automatic logic out_of_q16(input longint signed v);
    return (v > longint'(S32_MAX)) || (v < longint'(S32_MIN));
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint signed v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[DATA_W-1:0];
  endfunction

  // One line per mismatch
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  // Advance the solve by one matrix entry; a diagonal queues the row solution
  task automatic solve_step(input slts_in_t e);
    longint signed x_col;
    longint signed prod;
    longint signed diff;
    longint signed quot;
    int unsigned   rows_eff;
    slts_out_t     r;
    if (!e.is_diagonal) begin
      // unsolved columns, the row's own included, read as 1.0
      x_col = longint'(ONE_Q16);
      if (e.column < row_ptr) x_col = longint'(x_store[e.column]);
      prod = (longint'(e.coeff) * x_col) >>> 16;
      diff = longint'(acc) - prod;
      if (out_of_q16(diff)) acc_sat = 1'b1;
      acc = clamp_q16(diff);
    end else begin
      rows_eff = (row_limit == 0) ? 1 :
                 (row_limit > MAX_ROWS) ? MAX_ROWS : int'(row_limit);
      r.row_index = row_ptr[ROW_W-1:0];
      if (e.coeff == 0) begin
        r.solution = (acc >= 0) ? S32_MAX : S32_MIN;
        r.status   = STATUS_ZERO_DIAG;
        zero_diags_o++;
      end else begin
        quot       = (longint'(acc) * 65536) / longint'(e.coeff);
        r.solution = clamp_q16(quot);
        r.status   = (acc_sat || out_of_q16(quot)) ? STATUS_OVERFLOW : STATUS_OK;
        if (r.status == STATUS_OVERFLOW) saturations_o++;
      end
      x_store[row_ptr] = r.solution;
      // a lowered row count closes the matrix at the current row
      r.solve_done = (row_ptr + 1 >= rows_eff);
      if (r.solve_done) matrices_o++;
      row_ptr = r.solve_done ? 0 : row_ptr + 1;
      acc     = ONE_Q16;
      acc_sat = 1'b0;
      pending_solutions = {pending_solutions, r};
    end
  endtask

  task automatic check_result(input slts_out_t got);
    slts_out_t want;
    solved_rows_o++;
    if (pending_solutions.size() == 0) begin
      report_mismatch($sformatf("result with none expected: row %0d solution %h",
                                got.row_index, got.solution));
    end else begin
      want = pending_solutions.pop_front();
      if (got.row_index !== want.row_index)
        report_mismatch($sformatf("row_index got %0d want %0d", got.row_index,
                                  want.row_index));
      if (got.solution !== want.solution)
        report_mismatch($sformatf("row %0d solution got %h want %h", want.row_index,
                                  got.solution, want.solution));
      if (got.status !== want.status)
        report_mismatch($sformatf("row %0d status got %0d want %0d", want.row_index,
                                  got.status, want.status));
      if (got.solve_done !== want.solve_done)
        report_mismatch($sformatf("row %0d solve_done got %b want %b", want.row_index,
                                  got.solve_done, want.solve_done));
    end
  endtask

  // Results are compared before the entry of the same edge is absorbed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ptr   = 0;
      acc       = ONE_Q16;
      acc_sat   = 1'b0;
      row_limit = ROW_COUNT_RESET;
      pending_solutions.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      entries_o     = 0;
      solved_rows_o = 0;
      zero_diags_o  = 0;
      saturations_o = 0;
      matrices_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (cfg_we_i) row_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        entries_o++;
        solve_step(in_data_i);
      end
      pending_o = pending_solutions.size();
    end
  end

endmodule

[sim/tb_sparse_lower_triangular_solve_core.sv]
`timescale 1ns / 100ps
// Testbench top for sparse_lower_triangular_solve_core: clock, reset, CSR stimulus,
// random source gaps and sink stalls, watchdog and verdict.
// Depends on slts_pkg, the core RTL and slts_solve_checker.
module tb_sparse_lower_triangular_solve_core
  import slts_pkg::*;
();

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 135;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [ROW_COUNT_W-1:0] cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  slts_in_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  slts_out_t              out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned entries;
  int unsigned solved_rows;
  int unsigned zero_diags;
  int unsigned saturations;
  int unsigned matrices;

  // Stimulus-side view of where the solve stands, used to pick sensible columns
  int unsigned next_row;
  int unsigned rows_eff;
  bit          src_quiet;
  bit          sink_quiet;

  sparse_lower_triangular_solve_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  slts_solve_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .entries_o     (entries),
    .solved_rows_o (solved_rows),
    .zero_diags_o  (zero_diags),
    .saturations_o (saturations),
    .matrices_o    (matrices)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Magnitude in [lo, hi] with a random sign
  function automatic logic [DATA_W-1:0] signed_within(input int unsigned lo,
                                                      input int unsigned hi);
    logic [DATA_W-1:0] v;
    v = $urandom_range(lo, hi);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic logic [DATA_W-1:0] offdiag_coeff();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom();
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
    return signed_within(0, 32'h4000);
  endfunction

  function automatic logic [DATA_W-1:0] diag_coeff();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return signed_within(1, 255);
    if (pick == 2) return $urandom();
    if (pick == 3) return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
    return signed_within(32'h8000, 32'h30000);
  endfunction

  function automatic logic [ROW_COUNT_W-1:0] phase_rows(input int unsigned p);
    case (p)
      0:       return 13'd1;
      1:       return 13'd5;
      2:       return 13'd8191;
      3:       return 13'd0;
      4:       return 13'd16;
      5:       return 13'd4096;
      6:       return 13'd2;
      7:       return 13'd37;
      default: return 13'($urandom_range(3, 64));
    endcase
  endfunction

  // One transfer on the input channel; called and returning at a rising edge
  task automatic push_entry(input logic [COL_W-1:0] col, input logic [DATA_W-1:0] coeff,
                            input logic diag);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{column: col, coeff: coeff, is_diagonal: diag};
    do @(posedge clk); while (in_stall);
    if (diag) next_row = (next_row + 1 >= rows_eff) ? 0 : next_row + 1;
  endtask

  // Row count written only once the core has drained
  task automatic set_rows(input logic [ROW_COUNT_W-1:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_eff = (value == 0) ? 1 : (value > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(value);
  endtask

  // A CSR row: mostly solved columns, some noise columns anywhere, diagonal last
  task automatic push_row(output int unsigned n);
    int unsigned      terms;
    int unsigned      j;
    logic [COL_W-1:0] col;
    terms = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    for (j = 0; j < terms; j++) begin
      if (next_row != 0 && $urandom_range(0, 9) < 8)
        col = COL_W'($urandom_range(0, next_row - 1));
      else col = COL_W'($urandom_range(0, 4095));
      push_entry(col, offdiag_coeff(), 1'b0);
    end
    col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, 4095))
                                      : next_row[COL_W-1:0];
    push_entry(col, diag_coeff(), 1'b1);
    n = terms + 1;
  endtask

  // Sink: a fresh stall count per result, spent only while a result is offered
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    hold = $urandom_range(0, 10);
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = sink_quiet ? 0 : $urandom_range(0, 10);
        if (hold != 0) out_stall <= 1'b1;
      end else if (out_stall) begin
        if (out_valid && hold != 0) hold--;
        if (hold == 0) out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Timed out: %0d cycles without a transfer", idle);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned n;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    next_row   = 0;
    rows_eff   = MAX_ROWS_DEF;
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset row count, own and unsolved columns, extreme coefficients
    push_entry(12'd0, 32'h0000_8000, 1'b0);
    push_entry(12'd4095, S32_MAX, 1'b0);
    push_entry(12'd4095, S32_MIN, 1'b0);
    push_entry(12'd0, ONE_Q16, 1'b1);
    // zero diagonal with a positive accumulator
    push_entry(12'd0, -ONE_Q16, 1'b0);
    push_entry(12'd1, '0, 1'b1);
    // accumulator saturates low, then zero diagonal wins over overflow
    push_entry(12'd1, S32_MAX, 1'b0);
    push_entry(12'd2, '0, 1'b1);
    // division saturates
    push_entry(12'd3, 32'd1, 1'b1);
    // floor rounding of a negative product, truncating division by a negative
    push_entry(12'd2, 32'hFFFF_FFFF, 1'b0);
    push_entry(12'd3, 32'hFFFF_FFFF, 1'b0);
    push_entry(12'd4, 32'hFFFD_0000, 1'b1);
    set_rows(13'd6);
    push_entry(12'd0, 32'h0000_4000, 1'b0);
    push_entry(12'd5, 32'h0002_0000, 1'b1);
    push_entry(12'd0, ONE_Q16, 1'b1);
    push_entry(12'd0, ONE_Q16, 1'b0);
    push_entry(12'd1, ONE_Q16, 1'b1);
    // row count lowered below the current row
    set_rows(13'd1);
    push_entry(12'd2, ONE_Q16, 1'b1);
    // row count of zero acts as one
    set_rows(13'd0);
    push_entry(12'd0, -ONE_Q16, 1'b1);
    push_entry(12'd0, 32'h0000_8000, 1'b0);
    push_entry(12'd0, ONE_Q16, 1'b1);

    // Random phases, each under its own row count and idling mode
    for (p = 0; p < PHASES; p++) begin
      set_rows(phase_rows(p));
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      k = 0;
      while (k < PHASE_ITEMS) begin
        push_row(n);
        k += n;
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a divide still in flight
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d matrix entries and %0d row solutions over %0d row-count settings",
             entries, solved_rows, PHASES + 4);
    $display("  %0d zero diagonals, %0d saturated rows, %0d matrices closed",
             zero_diags, saturations, matrices);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sparse_lower_triangular_solve_core.f]
rtl/core/slts_pkg.sv
rtl/core/slts_ram.sv
rtl/core/slts_div.sv
rtl/core/sparse_lower_triangular_solve_core.sv
sim/slts_solve_checker.sv
sim/tb_sparse_lower_triangular_solve_core.sv
